### src/rip_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rip_pkg;

  // Field widths
  localparam int VALUE_BITS      = 32;
  localparam int COUNT_BITS      = 16;
  localparam int RADIX_BITS      = 6;
  localparam int CHAR_BITS       = 8;
  localparam int DIGIT_BITS      = 7;
  localparam int SEPARATOR_SLOTS = 4;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int CFG_DATA_BITS   = 32;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BASE_RADIX  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LEAD_SKIP   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SIGN_MODE   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPACE_AFTER = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HEX_ENABLE  = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SEPARATORS  = 3'd5;

  // Mode codes
  localparam logic [1:0] LEAD_SKIP_NONE  = 2'd0;
  localparam logic [1:0] LEAD_SKIP_SPACE = 2'd1;
  localparam logic [1:0] SIGN_NONE       = 2'd0;
  localparam logic [1:0] SIGN_MINUS      = 2'd1;

  localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_BITS-1:0] RADIX_HEX   = 6'd16;

  localparam logic [DIGIT_BITS-1:0] DIGIT_NONE = 7'd99;

  // Character codes
  localparam logic [CHAR_BITS-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_BITS-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_BITS-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_BITS-1:0] CH_UP_X  = 8'h58;
  localparam logic [CHAR_BITS-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CHAR_BITS-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_BITS-1:0] CH_LO_X  = 8'h78;
  localparam logic [CHAR_BITS-1:0] CH_LO_Z  = 8'h7A;

  typedef enum logic [1:0] {
    CAUSE_REJECT = 2'd0,
    CAUSE_NUL    = 2'd1,
    CAUSE_LAST   = 2'd2
  } rip_cause_t;

  // Per-field parsing rules
  typedef struct packed {
    logic neg;
    logic chk_minus;
    logic chk_sign;
    logic chk_hex;
    logic space_first;
    logic ws_first;
    logic space_after;
  } rip_flags_t;

  // Running number state
  typedef struct packed {
    logic [VALUE_BITS-1:0] acc;
    logic [RADIX_BITS-1:0] radix;
    rip_flags_t            flags;
    logic                  zero_digit;
    logic [COUNT_BITS-1:0] count;
  } rip_state_t;

  function automatic logic [RADIX_BITS-1:0] clamp_radix(input logic [RADIX_BITS-1:0] r);
    logic [RADIX_BITS-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    else if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  // Digit value of a character, DIGIT_NONE when it is no digit at all
  function automatic logic [DIGIT_BITS-1:0] digit_of(input logic [CHAR_BITS-1:0] c);
    logic [DIGIT_BITS-1:0] d;
    d = DIGIT_NONE;
    if (c inside {[CH_ZERO:CH_NINE]}) d = DIGIT_BITS'(c - CH_ZERO);
    else if (c inside {[CH_UP_A:CH_UP_Z]}) d = DIGIT_BITS'(c - CH_UP_A) + 7'd10;
    else if (c inside {[CH_LO_A:CH_LO_Z]}) d = DIGIT_BITS'(c - CH_LO_A) + 7'd10;
    return d;
  endfunction

endpackage

`default_nettype wire

### src/rip_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

// Character request channel
interface rip_char_if;
  import rip_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] ch;
  logic                 last;
  modport source (output valid, ch, last, input ready);
  modport sink (input valid, ch, last, output ready);
endinterface

// Parsed number channel
interface rip_result_if;
  import rip_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;
  logic [COUNT_BITS-1:0]        parsed_count;
  logic [1:0]                   end_cause;
  modport source (output valid, value, parsed_count, end_cause, input ready);
  modport sink (input valid, value, parsed_count, end_cause, output ready);
endinterface

// Register write channel
interface rip_cfg_if;
  import rip_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/rip_char_step.sv
`timescale 1ns / 1ps
`default_nettype none

// Judges one non-NUL character against the current rules and updates the number.
module rip_char_step import rip_pkg::*; (
  input  rip_state_t                         cur,
  input  logic [CHAR_BITS-1:0]               ch,
  input  logic [SEPARATOR_SLOTS*CHAR_BITS-1:0] separators,
  output rip_state_t                         nxt,
  output logic                               consumed
);

  logic                             is_blank;
  logic                             is_ws;
  logic                             acc_zero;
  logic                             sep_hit;
  logic [DIGIT_BITS-1:0]            digit;
  logic                             digit_ok;
  logic [VALUE_BITS+RADIX_BITS-1:0] product;

  assign is_blank = (ch == CH_SPACE) || (ch == CH_TAB);
  assign is_ws    = (ch == CH_TAB) || (ch == CH_LF) || (ch == CH_CR) || (ch == CH_FF);
  assign acc_zero = (cur.acc == '0);
  assign digit    = digit_of(ch);
  assign digit_ok = (digit < {1'b0, cur.radix});
  assign product  = {{RADIX_BITS{1'b0}}, cur.acc} * {{VALUE_BITS{1'b0}}, cur.radix};

  // Separator compare against all slots at once
  always_comb begin
    sep_hit = 1'b0;
    for (int i = 0; i < SEPARATOR_SLOTS; i++) begin
      if (separators[CHAR_BITS*i +: CHAR_BITS] != CH_NUL &&
          separators[CHAR_BITS*i +: CHAR_BITS] == ch) begin
        sep_hit = 1'b1;
      end
    end
  end

  always_comb begin
    logic taken;
    nxt      = cur;
    taken    = 1'b0;
    if (ch <= CH_SPACE) begin
      if (is_blank && (cur.flags.space_first || cur.flags.ws_first || cur.flags.space_after)) begin
        taken = 1'b1;
      end else if (is_ws && cur.flags.ws_first) begin
        taken = 1'b1;
      end
    end else if (cur.flags.chk_hex && (ch == CH_LO_X || ch == CH_UP_X) &&
                 cur.zero_digit && acc_zero) begin
      // 0x prefix switches to radix 16
      taken                   = 1'b1;
      nxt.radix               = RADIX_HEX;
      nxt.flags.chk_hex       = 1'b0;
      nxt.flags.space_first   = 1'b0;
      nxt.flags.ws_first      = 1'b0;
      nxt.flags.space_after   = 1'b0;
    end else if (ch == CH_MINUS && acc_zero && (cur.flags.chk_minus || cur.flags.chk_sign)) begin
      taken                   = 1'b1;
      nxt.flags.neg           = 1'b1;
      nxt.flags.chk_minus     = 1'b0;
      nxt.flags.chk_sign      = 1'b0;
      nxt.flags.space_first   = 1'b0;
      nxt.flags.ws_first      = 1'b0;
    end else if (ch == CH_PLUS && acc_zero && cur.flags.chk_sign) begin
      taken                   = 1'b1;
      nxt.flags.chk_minus     = 1'b0;
      nxt.flags.chk_sign      = 1'b0;
      nxt.flags.space_first   = 1'b0;
      nxt.flags.ws_first      = 1'b0;
    end else if (digit_ok) begin
      // Multiply-accumulate, wrapping at the value width
      taken                   = 1'b1;
      nxt.acc                 = product[VALUE_BITS-1:0] + VALUE_BITS'(digit);
      nxt.zero_digit          = (digit == '0);
      nxt.flags.space_first   = 1'b0;
      nxt.flags.ws_first      = 1'b0;
      nxt.flags.space_after   = 1'b0;
    end

    // Anything not taken above clears the leading rules; separators are still eaten
    if (!taken) begin
      nxt.flags.space_first   = 1'b0;
      nxt.flags.ws_first      = 1'b0;
      nxt.flags.space_after   = 1'b0;
      nxt.flags.chk_hex       = 1'b0;
      nxt.zero_digit          = 1'b0;
    end
    consumed = taken || sep_hit;

    // Saturating character count
    if (consumed && cur.count != '1) nxt.count = cur.count + COUNT_BITS'(1);
  end

endmodule

`default_nettype wire

### src/radix_integer_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// Character-stream integer parser. One character is taken per request on
// char_in; digits in the configured radix (2..36, letters in either case) build
// a 32-bit wrapping value, with optional leading-blank skipping, sign, blanks
// after the sign, a 0x prefix that switches to radix 16, and up to four
// separator bytes. The number ends at a rejected character, a NUL, or the
// character marked last; one result then carries the value (negated on a
// minus), the saturating count of consumed characters and the end cause.
// Characters after an early end are dropped through the next last one.
// Throughput is one character per clock while the result register is not held by
// a stalled result_out: each character passes through an input register, one
// multiply-add plus parallel compares, and the result register. The user must
// write registers on cfg only while no character is in flight (the block does not
// enforce this); rules and radix are latched at the first character of each field.
module radix_integer_parser import rip_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  rip_char_if.sink          char_in,
  rip_result_if.source      result_out,
  rip_cfg_if.sink           cfg
);

  // Configuration registers
  logic [RADIX_BITS-1:0]                base_radix;
  logic [1:0]                           lead_skip_mode;
  logic [1:0]                           sign_mode;
  logic                                 space_after_sign;
  logic                                 hex_prefix_enable;
  logic [SEPARATOR_SLOTS*CHAR_BITS-1:0] separator_chars;

  // Input register
  logic                 in_valid;
  logic [CHAR_BITS-1:0] in_ch;
  logic                 in_last;

  // Field state
  rip_state_t st;
  logic       started;
  logic       finished;

  // Result register
  logic                  out_valid;
  logic [VALUE_BITS-1:0] out_value;
  logic [COUNT_BITS-1:0] out_count;
  rip_cause_t            out_cause;

  rip_state_t fresh;
  rip_state_t cur;
  rip_state_t step;
  rip_state_t st_next;
  logic       consumed;
  logic       fire;
  logic       emit;
  rip_cause_t cause;
  logic       started_next;
  logic       finished_next;
  logic       cur_finished;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_radix        <= RADIX_RESET;
      lead_skip_mode    <= LEAD_SKIP_NONE;
      sign_mode         <= SIGN_NONE;
      space_after_sign  <= 1'b0;
      hex_prefix_enable <= 1'b0;
      separator_chars   <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_BASE_RADIX:  base_radix        <= cfg.data[RADIX_BITS-1:0];
        CFG_LEAD_SKIP:   lead_skip_mode    <= cfg.data[1:0];
        CFG_SIGN_MODE:   sign_mode         <= cfg.data[1:0];
        CFG_SPACE_AFTER: space_after_sign  <= cfg.data[0];
        CFG_HEX_ENABLE:  hex_prefix_enable <= cfg.data[0];
        CFG_SEPARATORS:  separator_chars   <= cfg.data[SEPARATOR_SLOTS*CHAR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: process the held character when the result slot is free or draining
  assign fire          = in_valid && (!out_valid || result_out.ready);
  assign char_in.ready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (char_in.ready) begin
      in_valid <= char_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_in.ready) begin
      in_ch   <= char_in.ch;
      in_last <= char_in.last;
    end
  end

  // State at the start of a field
  always_comb begin
    fresh                   = '0;
    fresh.radix             = clamp_radix(base_radix);
    fresh.flags.space_first = (lead_skip_mode == LEAD_SKIP_SPACE);
    fresh.flags.ws_first    = (lead_skip_mode > LEAD_SKIP_SPACE);
    fresh.flags.chk_minus   = (sign_mode == SIGN_MINUS);
    fresh.flags.chk_sign    = (sign_mode > SIGN_MINUS);
    fresh.flags.space_after = space_after_sign;
    fresh.flags.chk_hex     = hex_prefix_enable;
  end

  assign cur          = started ? st : fresh;
  assign cur_finished = started && finished;

  rip_char_step u_step (
    .cur        (cur),
    .ch         (in_ch),
    .separators (separator_chars),
    .nxt        (step),
    .consumed   (consumed)
  );

  // End detection and field bookkeeping
  always_comb begin
    st_next       = cur;
    emit          = 1'b0;
    cause         = CAUSE_REJECT;
    started_next  = 1'b1;
    finished_next = cur_finished;
    if (cur_finished) begin
      if (in_last) started_next = 1'b0;
    end else if (in_ch == CH_NUL) begin
      emit  = 1'b1;
      cause = CAUSE_NUL;
    end else if (consumed) begin
      st_next = step;
      emit    = in_last;
      cause   = CAUSE_LAST;
    end else begin
      st_next = step;
      emit    = 1'b1;
      cause   = CAUSE_REJECT;
    end
    if (emit) begin
      if (in_last) started_next = 1'b0;
      else finished_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started  <= 1'b0;
      finished <= 1'b0;
    end else if (fire) begin
      started  <= started_next;
      finished <= finished_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) st <= st_next;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && emit) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_value <= st_next.flags.neg ? (VALUE_BITS'(0) - st_next.acc) : st_next.acc;
      out_count <= st_next.count;
      out_cause <= cause;
    end
  end

  assign result_out.valid        = out_valid;
  assign result_out.value        = out_value;
  assign result_out.parsed_count = out_count;
  assign result_out.end_cause    = out_cause;

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rip_pkg::*;

  // Mode codes and characters not named by the package
  localparam logic [1:0] LEAD_SKIP_ALL = 2'd2;
  localparam logic [1:0] SIGN_BOTH     = 2'd2;
  localparam logic [1:0] MODE_SPARE    = 2'd3;
  localparam logic [CHAR_BITS-1:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [CHAR_BITS-1:0] CH_COMMA      = 8'h2C;
  localparam logic [CHAR_BITS-1:0] CH_NBSP       = 8'hA0;
  localparam int NO_DIGIT       = 64;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_CHARS   = 520;
  localparam int SETTLE_CYCLES  = 8;

  typedef struct {
    logic signed [VALUE_BITS-1:0] value;
    logic [COUNT_BITS-1:0]        count;
    rip_cause_t                   cause;
  } number_t;

  logic clk;
  logic rst;

  rip_char_if   char_bus ();
  rip_result_if num_bus ();
  rip_cfg_if    cfg_bus ();

  radix_integer_parser u_top (
    .clk        (clk),
    .rst        (rst),
    .char_in    (char_bus),
    .result_out (num_bus),
    .cfg        (cfg_bus)
  );

  // Register copies
  logic [RADIX_BITS-1:0]    reg_radix;
  logic [1:0]               reg_lead;
  logic [1:0]               reg_sign;
  logic                     reg_space_after;
  logic                     reg_hex;
  logic [CFG_DATA_BITS-1:0] reg_seps;

  // Field state of the parser model
  logic [VALUE_BITS-1:0] acc_val;
  logic [RADIX_BITS-1:0] cur_radix;
  rip_flags_t            cur_rules;
  logic                  zero_seen;
  logic [COUNT_BITS-1:0] consumed;
  logic                  field_done;
  logic                  field_open;

  number_t numbers_due[$];
  bit      send_stall;
  bit      recv_stall;
  int      n_chars = 0;
  int      n_numbers = 0;
  int      n_writes = 0;
  int      n_bad = 0;
  int      idle_cycles = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int usable_radix(input logic [RADIX_BITS-1:0] r);
    if (r < RADIX_MIN) return int'(RADIX_MIN);
    if (r > RADIX_MAX) return int'(RADIX_MAX);
    return int'(r);
  endfunction

  function automatic int char_digit(input logic [CHAR_BITS-1:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_UP_A && c <= CH_UP_Z) return int'(c - CH_UP_A) + 10;
    if (c >= CH_LO_A && c <= CH_LO_Z) return int'(c - CH_LO_A) + 10;
    return NO_DIGIT;
  endfunction

  // Separator bytes are looked up live, zero slots never match
  function automatic bit is_separator(input logic [CHAR_BITS-1:0] c);
    for (int i = 0; i < SEPARATOR_SLOTS; i++)
      if (reg_seps[8*i +: 8] != 8'd0 && reg_seps[8*i +: 8] == c) return 1'b1;
    return 1'b0;
  endfunction

  // Latch rules and radix at the first character of a field
  function automatic void open_field();
    cur_rules = '0;
    if (reg_lead == LEAD_SKIP_SPACE) cur_rules.space_first = 1'b1;
    else if (reg_lead >= LEAD_SKIP_ALL) cur_rules.ws_first = 1'b1;
    if (reg_sign == SIGN_MINUS) cur_rules.chk_minus = 1'b1;
    else if (reg_sign >= SIGN_BOTH) cur_rules.chk_sign = 1'b1;
    cur_rules.space_after = reg_space_after;
    cur_rules.chk_hex = reg_hex;
    cur_radix = RADIX_BITS'(usable_radix(reg_radix));
    acc_val = '0;
    zero_seen = 1'b0;
    consumed = '0;
    field_done = 1'b0;
    field_open = 1'b1;
  endfunction

  // One non-NUL character; returns 1 when it is consumed
  function automatic bit consume_char(input logic [CHAR_BITS-1:0] c);
    rip_flags_t st;
    int d;
    st = cur_rules;
    if (c <= CH_SPACE) begin
      if ((c == CH_SPACE || c == CH_TAB) && (st.space_first || st.ws_first || st.space_after))
        return 1'b1;
      if ((c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_FF) && st.ws_first)
        return 1'b1;
    end else if (st.chk_hex && (c == CH_LO_X || c == CH_UP_X) && zero_seen && acc_val == '0) begin
      cur_radix = RADIX_HEX;
      cur_rules.chk_hex = 1'b0;
      cur_rules.space_first = 1'b0;
      cur_rules.ws_first = 1'b0;
      cur_rules.space_after = 1'b0;
      return 1'b1;
    end else if (c == CH_MINUS && acc_val == '0 && (st.chk_minus || st.chk_sign)) begin
      cur_rules.neg = 1'b1;
      cur_rules.chk_minus = 1'b0;
      cur_rules.chk_sign = 1'b0;
      cur_rules.space_first = 1'b0;
      cur_rules.ws_first = 1'b0;
      return 1'b1;
    end else if (c == CH_PLUS && acc_val == '0 && st.chk_sign) begin
      cur_rules.chk_minus = 1'b0;
      cur_rules.chk_sign = 1'b0;
      cur_rules.space_first = 1'b0;
      cur_rules.ws_first = 1'b0;
      return 1'b1;
    end else begin
      d = char_digit(c);
      if (d < int'(cur_radix)) begin
        acc_val = acc_val * {{(VALUE_BITS-RADIX_BITS){1'b0}}, cur_radix} + VALUE_BITS'(d);
        zero_seen = (d == 0);
        cur_rules.space_first = 1'b0;
        cur_rules.ws_first = 1'b0;
        cur_rules.space_after = 1'b0;
        return 1'b1;
      end
    end
    // Anything else ends blank skipping and the prefix window
    cur_rules = st;
    cur_rules.space_first = 1'b0;
    cur_rules.ws_first = 1'b0;
    cur_rules.space_after = 1'b0;
    cur_rules.chk_hex = 1'b0;
    zero_seen = 1'b0;
    return is_separator(c);
  endfunction

  // Advance the model by one character; returns 1 when a number comes out
  function automatic bit parse_char(input logic [CHAR_BITS-1:0] c, input logic is_last,
                                    output number_t num);
    rip_cause_t why;
    if (!field_open) open_field();
    if (field_done) begin
      if (is_last) field_open = 1'b0;
      return 1'b0;
    end
    if (c == CH_NUL) begin
      why = CAUSE_NUL;
    end else if (consume_char(c)) begin
      if (consumed != '1) consumed++;
      if (!is_last) return 1'b0;
      why = CAUSE_LAST;
    end else begin
      why = CAUSE_REJECT;
    end
    num.value = cur_rules.neg ? -acc_val : acc_val;
    num.count = consumed;
    num.cause = why;
    if (is_last) field_open = 1'b0;
    else field_done = 1'b1;
    return 1'b1;
  endfunction

  function automatic logic [CHAR_BITS-1:0] pick_blank();
    case ($urandom_range(0, 4))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_CR;
      default: return CH_FF;
    endcase
  endfunction

  // Character request: optional gap, then hold until accepted
  task automatic put_char(input logic [CHAR_BITS-1:0] c, input logic is_last);
    int gap;
    number_t num;
    gap = send_stall ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      char_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_bus.valid <= 1'b1;
    char_bus.ch <= c;
    char_bus.last <= is_last;
    do @(posedge clk); while (!char_bus.ready);
    n_chars++;
    if (parse_char(c, is_last, num)) numbers_due.push_back(num);
  endtask

  task automatic put_text(input string s, input bit ends_field);
    for (int i = 0; i < s.len(); i++)
      put_char(s[i], ends_field && i == s.len() - 1);
  endtask

  // Quiet the character side and let every pending number come out
  task automatic drain();
    char_bus.valid <= 1'b0;
    while (numbers_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    n_writes++;
    case (idx)
      CFG_BASE_RADIX:  reg_radix = data[RADIX_BITS-1:0];
      CFG_LEAD_SKIP:   reg_lead = data[1:0];
      CFG_SIGN_MODE:   reg_sign = data[1:0];
      CFG_SPACE_AFTER: reg_space_after = data[0];
      CFG_HEX_ENABLE:  reg_hex = data[0];
      CFG_SEPARATORS:  reg_seps = data;
      default: ;
    endcase
  endtask

  // Full register set; unused upper data bits carry junk
  task automatic set_rules(input logic [RADIX_BITS-1:0] radix, input logic [1:0] lead,
                           input logic [1:0] sign, input logic sa, input logic hx,
                           input logic [CFG_DATA_BITS-1:0] seps);
    logic [CFG_DATA_BITS-1:0] junk;
    drain();
    junk = $urandom();
    write_reg(CFG_BASE_RADIX, {junk[31:RADIX_BITS], radix});
    write_reg(CFG_LEAD_SKIP, {junk[31:2], lead});
    write_reg(CFG_SIGN_MODE, {junk[31:2], sign});
    write_reg(CFG_SPACE_AFTER, {junk[31:1], sa});
    write_reg(CFG_HEX_ENABLE, {junk[31:1], hx});
    write_reg(CFG_SEPARATORS, seps);
    cfg_bus.valid <= 1'b0;
  endtask

  // Reset values: radix 10, no rules
  task automatic test_reset_rules();
    put_text("12", 1'b1);
    put_text("4a9", 1'b1);
    put_text("7", 1'b0);
    put_char(CH_NUL, 1'b1);
    put_char(8'hFF, 1'b1);
  endtask

  // Out-of-range radix clamps; letter digit equal to radix is rejected
  task automatic test_radix_limits();
    set_rules(6'd0, LEAD_SKIP_NONE, SIGN_NONE, 1'b0, 1'b0, '0);
    put_text("10", 1'b1);
    set_rules(6'd63, LEAD_SKIP_NONE, SIGN_NONE, 1'b0, 1'b0, '0);
    put_text("z", 1'b1);
    set_rules(6'd35, LEAD_SKIP_NONE, SIGN_NONE, 1'b0, 1'b0, '0);
    put_text("Z", 1'b1);
  endtask

  // Leading whitespace, blanks after sign, sign after zeros
  task automatic test_signs_and_blanks();
    set_rules(RADIX_RESET, LEAD_SKIP_ALL, SIGN_BOTH, 1'b1, 1'b0, '0);
    put_text("\n- 4", 1'b1);
    put_text("0-9", 1'b1);
    set_rules(RADIX_RESET, MODE_SPARE, MODE_SPARE, 1'b0, 1'b0, '0);
    put_char(CH_FF, 1'b0);
    put_char(CH_CR, 1'b0);
    put_text("+7", 1'b1);
  endtask

  // Prefix switch, digit judged against 16, and the most negative value
  task automatic test_hex_prefix();
    set_rules(RADIX_MAX, LEAD_SKIP_NONE, SIGN_MINUS, 1'b0, 1'b1, '0);
    put_text("-0xg", 1'b1);
    put_text("1x", 1'b1);
    set_rules(RADIX_RESET, LEAD_SKIP_NONE, SIGN_MINUS, 1'b0, 1'b1, '0);
    put_text("-0X80000000", 1'b1);
  endtask

  // Separator kills the prefix window; high bytes as separators
  task automatic test_separators();
    set_rules(RADIX_RESET, LEAD_SKIP_NONE, SIGN_NONE, 1'b0, 1'b1,
              {8'h00, CH_NBSP, CH_COMMA, CH_UNDERSCORE});
    put_text("0_x", 1'b1);
    put_text("1_,", 1'b0);
    put_char(CH_NBSP, 1'b0);
    put_text("5", 1'b1);
  endtask

  // Writes inside an open field: radix and rules wait, separators apply now
  task automatic test_mid_field_writes();
    set_rules(RADIX_RESET, LEAD_SKIP_NONE, SIGN_NONE, 1'b0, 1'b0, '0);
    put_text("1", 1'b0);
    drain();
    write_reg(CFG_BASE_RADIX, CFG_DATA_BITS'(RADIX_MIN));
    write_reg(CFG_SIGN_MODE, CFG_DATA_BITS'(SIGN_MINUS));
    write_reg(CFG_SEPARATORS, {24'd0, CH_UNDERSCORE});
    cfg_bus.valid <= 1'b0;
    put_text("_9", 1'b1);
    put_text("-11", 1'b1);
  endtask

  // Random settings, mostly well-formed numbers with random endings
  task automatic test_random_text();
    int goal;
    int r;
    int n;
    int d;
    logic [RADIX_BITS-1:0] radix;
    logic [CFG_DATA_BITS-1:0] seps;
    logic [CHAR_BITS-1:0] c;
    logic [CHAR_BITS-1:0] sep_list[$];
    logic [CHAR_BITS-1:0] text[$];
    goal = n_chars + RANDOM_CHARS;
    while (n_chars < goal) begin
      case ($urandom_range(0, 9))
        0: radix = 6'd0;
        1: radix = 6'd1;
        2: radix = 6'd63;
        3: radix = 6'd37;
        4: radix = RADIX_MIN;
        5: radix = RADIX_MAX;
        default: radix = RADIX_BITS'($urandom_range(2, 36));
      endcase
      for (int k = 0; k < SEPARATOR_SLOTS; k++) begin
        case ($urandom_range(0, 3))
          0: seps[8*k +: 8] = 8'd0;
          1: seps[8*k +: 8] = 8'($urandom_range(33, 47));
          2: seps[8*k +: 8] = 8'($urandom_range(128, 255));
          default: seps[8*k +: 8] = 8'($urandom_range(1, 255));
        endcase
      end
      set_rules(radix, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), seps);
      sep_list.delete();
      for (int k = 0; k < SEPARATOR_SLOTS; k++)
        if (reg_seps[8*k +: 8] != 8'd0) sep_list.push_back(reg_seps[8*k +: 8]);
      send_stall = $urandom_range(0, 2) != 0;
      recv_stall = $urandom_range(0, 2) != 0;

      repeat ($urandom_range(8, 16)) begin
        text.delete();
        if ($urandom_range(0, 3) == 0) begin
          // Noise field
          repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
        end else begin
          if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) text.push_back(pick_blank());
          if ($urandom_range(0, 1) == 1) begin
            text.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
            if ($urandom_range(0, 2) == 0)
              repeat ($urandom_range(1, 2)) text.push_back(pick_blank());
          end
          r = usable_radix(reg_radix);
          if (reg_hex && $urandom_range(0, 2) == 0) begin
            text.push_back(CH_ZERO);
            text.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
            r = int'(RADIX_HEX);
          end
          // Long runs now and then so the value wraps
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
          for (int i = 0; i < n; i++) begin
            d = $urandom_range(0, r - 1);
            if (d < 10) c = CH_ZERO + 8'(d);
            else c = ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + 8'(d - 10);
            text.push_back(c);
            if (sep_list.size() > 0 && $urandom_range(0, 5) == 0)
              text.push_back(sep_list[$urandom_range(0, sep_list.size() - 1)]);
          end
          // Ending: last on a digit, a stray byte, or NUL, then maybe trailing junk
          case ($urandom_range(0, 5))
            3: begin
              text.push_back(8'($urandom_range(0, 255)));
              repeat ($urandom_range(0, 3)) text.push_back(8'($urandom_range(0, 255)));
            end
            4: text.push_back(CH_NUL);
            5: begin
              text.push_back(CH_NUL);
              repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(0, 255)));
            end
            default: ;
          endcase
        end
        foreach (text[i]) put_char(text[i], i == text.size() - 1);
      end
    end
    send_stall = 1'b1;
    recv_stall = 1'b1;
  endtask

  // Result side: random hold-off before each number
  initial begin : drive_ready
    int gap;
    num_bus.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      gap = recv_stall ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        num_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      num_bus.ready <= 1'b1;
      do @(posedge clk); while (!num_bus.valid);
    end
  end

  // Compare each number with the oldest prediction; watchdog on progress
  always @(posedge clk) begin : check_numbers
    number_t want;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (num_bus.valid && num_bus.ready) begin
        n_numbers++;
        if (numbers_due.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("number %0d not predicted: value=%0d count=%0d cause=%0d", n_numbers,
                     num_bus.value, num_bus.parsed_count, num_bus.end_cause);
        end else begin
          want = numbers_due.pop_front();
          if (num_bus.value !== want.value || num_bus.parsed_count !== want.count ||
              num_bus.end_cause !== want.cause) begin
            n_bad++;
            if (n_bad <= 10)
              $display("number %0d: expected value=%0d count=%0d cause=%s, got %0d %0d %0d",
                       n_numbers, want.value, want.count, want.cause.name(),
                       num_bus.value, num_bus.parsed_count, num_bus.end_cause);
          end
        end
      end
      if ((char_bus.valid && char_bus.ready) || (num_bus.valid && num_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no request accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    char_bus.valid = 1'b0;
    char_bus.ch = '0;
    char_bus.last = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    send_stall = 1'b1;
    recv_stall = 1'b1;
    reg_radix = RADIX_RESET;
    reg_lead = LEAD_SKIP_NONE;
    reg_sign = SIGN_NONE;
    reg_space_after = 1'b0;
    reg_hex = 1'b0;
    reg_seps = '0;
    field_open = 1'b0;
    field_done = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_rules();
    test_radix_limits();
    test_signs_and_blanks();
    test_hex_prefix();
    test_separators();
    test_mid_field_writes();
    test_random_text();
    drain();

    $display("Ran %0d characters, checked %0d numbers, %0d register writes, %0d mismatches",
             n_chars, n_numbers, n_writes, n_bad);
    $display("Covered clamped radices, sign/blank/prefix/separator rules, NUL and reject ends,");
    $display("mid-field writes and random text under stalls on both sides");
    if (n_bad == 0 && numbers_due.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

### filelist.f
src/rip_pkg.sv
src/rip_ifs.sv
src/rip_char_step.sv
src/radix_integer_parser.sv
verif/testbench.sv
